// ===== hw/rtl/ini_line_tokenizer_assert.svh =====
// assertion macros for the tokenizer rtl
`ifndef INI_LINE_TOKENIZER_ASSERT_SVH
`define INI_LINE_TOKENIZER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ILT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer check failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define ILT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer check failed: next-cycle implication");

`endif

// ===== hw/rtl/ilt_pkg.sv =====
package ilt_pkg;

   // line parse steps
   typedef enum logic [2:0] {
      STEP_FIRST,
      STEP_KEY,
      STEP_BLANKS,
      STEP_VALUE,
      STEP_SECTION,
      STEP_AFTER_BRACKET,
      STEP_COMMENT,
      STEP_BAD
   } step_type;

   // result kinds
   typedef enum logic [3:0] {
      KIND_KEY_CHAR     = 4'd0,
      KIND_SECTION_CHAR = 4'd1,
      KIND_VALUE_CHAR   = 4'd2,
      KIND_SETTING      = 4'd3,
      KIND_SECTION_DONE = 4'd4,
      KIND_BAD_SKIPPED  = 4'd5,
      KIND_BAD_FATAL    = 4'd6,
      KIND_TOO_LONG     = 4'd7,
      KIND_ENDED        = 4'd8
   } kind_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_KEY_LINE_LIMIT = 2'd0,
      CSR_SECTION_LIMIT  = 2'd1,
      CSR_SKIP_BAD_LINES = 2'd2
   } csr_index_type;

   localparam logic [7:0]  KEY_LINE_LIMIT_RESET = 8'd64;
   localparam logic [7:0]  SECTION_LIMIT_RESET  = 8'd32;
   localparam logic        SKIP_BAD_RESET       = 1'b0;
   localparam logic [15:0] LINE_FIRST           = 16'd1;
   localparam logic [15:0] LINE_MAX             = 16'hFFFF;

   typedef struct packed {
      logic [7:0] key_line_limit;
      logic [7:0] section_limit;
      logic       skip_bad_lines;
   } cfg_type;

   typedef struct packed {
      step_type    step;
      logic        saw_bracket;
      logic [7:0]  fill_count;
      logic [15:0] line_count;
      logic        stopped;
      logic        use_section_limit;
   } parse_state_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  char_out;
      logic [7:0]  char_position;
      logic [15:0] line_number;
      logic        halted;
   } rsp_item_type;

endpackage

// ===== hw/rtl/ilt_step.sv =====
module ilt_step (
   input  ilt_pkg::parse_state_type cur,
   input  ilt_pkg::cfg_type         cfg,
   input  logic [7:0]               text_byte,
   input  logic                     end_of_input,
   output ilt_pkg::parse_state_type nxt,
   output logic                     emit,
   output ilt_pkg::rsp_item_type    item
);
   import ilt_pkg::*;

   localparam logic [7:0] CHAR_HASH   = 8'h23;
   localparam logic [7:0] CHAR_LBRACK = 8'h5B;
   localparam logic [7:0] CHAR_RBRACK = 8'h5D;
   localparam logic [7:0] CHAR_EQUAL  = 8'h3D;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;

   logic       is_blank;
   logic       is_eol;
   logic       has_outcome;
   logic       outcome_fatal;
   kind_type   outcome;
   logic [7:0] limit;
   logic [7:0] fill_inc;

   assign is_blank = (text_byte == CHAR_SPACE) || (text_byte == CHAR_TAB);
   assign is_eol   = (text_byte == CHAR_CR) || (text_byte == CHAR_LF);
   assign limit    = cur.use_section_limit ? cfg.section_limit : cfg.key_line_limit;
   // fill stays below limit before it grows, so no wrap
   assign fill_inc = cur.fill_count + 8'd1;

   // outcome of the line finished by this byte
   always_comb begin
      has_outcome   = 1'b1;
      outcome_fatal = 1'b0;
      outcome       = KIND_SETTING;
      unique case (cur.step)
         STEP_VALUE:         outcome = KIND_SETTING;
         STEP_AFTER_BRACKET: outcome = KIND_SECTION_DONE;
         STEP_KEY, STEP_BLANKS, STEP_SECTION, STEP_BAD: begin
            if (cfg.skip_bad_lines) begin
               outcome = KIND_BAD_SKIPPED;
            end else begin
               outcome       = KIND_BAD_FATAL;
               outcome_fatal = 1'b1;
            end
         end
         default: has_outcome = 1'b0;
      endcase
   end

   always_comb begin
      nxt                = cur;
      emit               = 1'b0;
      item.kind          = KIND_KEY_CHAR;
      item.char_out      = 8'd0;
      item.char_position = cur.fill_count;
      item.line_number   = cur.line_count;

      if (!cur.stopped) begin
         priority if (end_of_input) begin
            nxt.step              = STEP_FIRST;
            nxt.saw_bracket       = 1'b0;
            nxt.fill_count        = 8'd0;
            nxt.use_section_limit = 1'b0;
            nxt.stopped           = 1'b1;
            emit                  = 1'b1;
            item.kind             = has_outcome ? outcome : KIND_ENDED;
         end else if (is_eol) begin
            nxt.step              = STEP_FIRST;
            nxt.saw_bracket       = 1'b0;
            nxt.fill_count        = 8'd0;
            nxt.use_section_limit = 1'b0;
            nxt.stopped           = outcome_fatal;
            if ((text_byte == CHAR_LF) && (cur.line_count != LINE_MAX)) begin
               nxt.line_count = cur.line_count + 16'd1;
            end
            emit      = has_outcome;
            item.kind = outcome;
         end else begin
            unique case (cur.step)
               STEP_KEY, STEP_BLANKS, STEP_VALUE, STEP_SECTION: begin
                  if (cur.fill_count >= limit) begin
                     nxt.stopped = 1'b1;
                     emit        = 1'b1;
                     item.kind   = KIND_TOO_LONG;
                  end else begin
                     unique case (cur.step)
                        STEP_KEY: begin
                           nxt.fill_count = fill_inc;
                           priority if (is_blank) begin
                              nxt.step = STEP_BLANKS;
                           end else if (text_byte == CHAR_EQUAL) begin
                              nxt.step = STEP_VALUE;
                           end else begin
                              emit          = 1'b1;
                              item.kind     = KIND_KEY_CHAR;
                              item.char_out = text_byte;
                           end
                        end
                        STEP_SECTION: begin
                           nxt.fill_count = fill_inc;
                           if (text_byte == CHAR_RBRACK) begin
                              nxt.step = STEP_AFTER_BRACKET;
                           end else begin
                              emit          = 1'b1;
                              item.kind     = KIND_SECTION_CHAR;
                              item.char_out = text_byte;
                           end
                        end
                        STEP_BLANKS: begin
                           priority if (text_byte == CHAR_EQUAL) begin
                              nxt.step = STEP_VALUE;
                           end else if (!is_blank) begin
                              nxt.step = STEP_BAD;
                           end
                        end
                        default: begin
                           nxt.fill_count = fill_inc;
                           emit           = 1'b1;
                           item.kind      = KIND_VALUE_CHAR;
                           item.char_out  = text_byte;
                        end
                     endcase
                  end
               end
               STEP_AFTER_BRACKET: begin
                  if (!is_blank) begin
                     nxt.step = STEP_BAD;
                  end
               end
               STEP_FIRST: begin
                  priority if (text_byte == CHAR_HASH) begin
                     nxt.step = STEP_COMMENT;
                  end else if (is_blank) begin
                     nxt.step = STEP_FIRST;
                  end else if (text_byte == CHAR_LBRACK) begin
                     nxt.saw_bracket = 1'b1;
                  end else begin
                     nxt.use_section_limit = cur.saw_bracket;
                     nxt.step       = cur.saw_bracket ? STEP_SECTION : STEP_KEY;
                     nxt.fill_count = 8'd1;
                     emit           = 1'b1;
                     item.kind      = cur.saw_bracket ? KIND_SECTION_CHAR : KIND_KEY_CHAR;
                     item.char_out  = text_byte;
                     item.char_position = 8'd0;
                  end
               end
               default: nxt.step = cur.step;
            endcase
         end
      end

      item.halted = nxt.stopped;
   end

endmodule

// ===== hw/rtl/ini_line_tokenizer.sv =====
// channel  | dir | handshake              | payload
// req      | in  | req_tvalid/req_tready  | tdata text_byte, tlast end_of_input
// rsp      | out | rsp_tvalid/rsp_tready  | tuser kind, tdata char/pos/line/halted
// csr      | in  | csr_valid/csr_ready    | csr_index, csr_data
//
// one byte per cycle sustained while rsp_tready stays high; a byte passes the input
// register, the parse logic and the result register, which drives rsp_tvalid
// the parse state register is the one loop: each byte sees the state left by the last
// a stalled rsp side holds the result register and the input register, and
// req_tready drops only while both are full
// reset (synchronous, active high) restores the register defaults and line one
// csr_ready is always high; writes go straight to the registers
module ini_line_tokenizer (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tlast,   // end_of_input
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] char_out, [15:8] char_position,
                                    // [31:16] line_number, [32] halted, [39:33] zero
   output logic [3:0]  rsp_tuser,   // [3:0] kind
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import ilt_pkg::*;

   // input register
   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff, in_byte_in;
   logic                  in_end_ff, in_end_in;
   // parse state and configuration
   parse_state_type       state_ff, state_in;
   cfg_type               cfg_ff, cfg_in;
   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_item_type          rsp_item_ff, rsp_item_in;

   parse_state_type       step_nxt;
   logic                  step_emit;
   rsp_item_type          step_item;
   logic                  advance;
   logic                  rsp_load;
   logic                  rsp_fatal_out;

   ilt_step u_step (
      .cur          (state_ff),
      .cfg          (cfg_ff),
      .text_byte    (in_byte_ff),
      .end_of_input (in_end_ff),
      .nxt          (step_nxt),
      .emit         (step_emit),
      .item         (step_item)
   );

   // the buffered byte moves on when the result register is free or being emptied
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign rsp_load   = advance && step_emit;
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_end_in   = in_end_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
         in_end_in   = req_tlast;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      state_in = advance ? step_nxt : state_ff;

      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (advance) begin
         rsp_valid_in = step_emit;
         if (step_emit) begin
            rsp_item_in = step_item;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_KEY_LINE_LIMIT: cfg_in.key_line_limit = csr_data;
            CSR_SECTION_LIMIT:  cfg_in.section_limit  = csr_data;
            CSR_SKIP_BAD_LINES: cfg_in.skip_bad_lines = csr_data[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff                  <= 1'b0;
         rsp_valid_ff                 <= 1'b0;
         state_ff.step                <= STEP_FIRST;
         state_ff.saw_bracket         <= 1'b0;
         state_ff.fill_count          <= 8'd0;
         state_ff.line_count          <= LINE_FIRST;
         state_ff.stopped             <= 1'b0;
         state_ff.use_section_limit   <= 1'b0;
         cfg_ff.key_line_limit        <= KEY_LINE_LIMIT_RESET;
         cfg_ff.section_limit         <= SECTION_LIMIT_RESET;
         cfg_ff.skip_bad_lines        <= SKIP_BAD_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
      end
      // payload, no reset needed
      in_byte_ff  <= in_byte_in;
      in_end_ff   <= in_end_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_item_ff.kind;
   assign rsp_tdata  = {7'd0, rsp_item_ff.halted, rsp_item_ff.line_number,
                        rsp_item_ff.char_position, rsp_item_ff.char_out};

   // a fatal kind or the end mark is on the result channel
   assign rsp_fatal_out = rsp_valid_ff && ((rsp_item_ff.kind == KIND_TOO_LONG) ||
                                           (rsp_item_ff.kind == KIND_BAD_FATAL) ||
                                           (rsp_item_ff.kind == KIND_ENDED));

   // once halted, the parser never resumes until reset
   `include "ini_line_tokenizer_assert.svh"
   `ILT_ASSERT_NEXT(a_halt_sticks, clock, reset, state_ff.stopped, state_ff.stopped)
   // a halted parser never loads a new result
   `ILT_ASSERT_NOW(a_halt_silent, clock, reset, state_ff.stopped, !rsp_load)
   // fatal kinds and the end mark always carry the halted flag
   `ILT_ASSERT_NOW(a_fatal_halts, clock, reset, rsp_fatal_out, rsp_item_ff.halted)

endmodule
